### rtl/slsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsd_pkg
// Shared types and constants for the sync/length/sum deframer.
// ----------------------------------------------------------------------------
package slsd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        t_byte data_byte;
        logic  is_frame_data;
        logic  frame_end;
        logic  checksum_good;
    } t_result;

endpackage

### rtl/slsd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsd_core
// Frame tracking state: sync hunt, length count and running checksum.
// Updates on each accepted word and gives that word's result combinationally.
// ----------------------------------------------------------------------------
module slsd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  slsd_pkg::t_byte   i_rx_byte,
    input  slsd_pkg::t_byte   i_sync_first,
    input  slsd_pkg::t_byte   i_sync_second,
    output slsd_pkg::t_result o_result
);
    import slsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_LEN,
        PH_BODY,
        PH_CSUM
    } t_phase;

    t_phase  r_phase, n_phase;
    t_byte   r_bytes_left, n_bytes_left;
    t_byte   r_running_sum, n_running_sum;
    t_result n_result;

    always_comb begin
        n_phase       = r_phase;
        n_bytes_left  = r_bytes_left;
        n_running_sum = r_running_sum;
        n_result               = '0;
        n_result.data_byte     = i_rx_byte;
        case (r_phase)
            PH_HUNT2: begin
                if (i_rx_byte == i_sync_second) begin
                    n_phase = PH_LEN;
                end else if (i_rx_byte == i_sync_first) begin
                    n_phase = PH_HUNT2;
                end else begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_LEN: begin
                n_result.is_frame_data = 1'b1;
                if (i_rx_byte == '0) begin
                    n_result.frame_end     = 1'b1;
                    n_result.checksum_good = 1'b1;
                    n_running_sum          = '0;
                    n_bytes_left           = '0;
                    n_phase                = PH_HUNT1;
                end else begin
                    n_running_sum = i_rx_byte;
                    n_bytes_left  = i_rx_byte - t_byte'(1);
                    n_phase       = (i_rx_byte == t_byte'(1)) ? PH_CSUM : PH_BODY;
                end
            end
            PH_BODY: begin
                n_result.is_frame_data = 1'b1;
                n_running_sum          = r_running_sum + i_rx_byte;
                n_bytes_left           = r_bytes_left - t_byte'(1);
                if (r_bytes_left == t_byte'(1)) begin
                    n_phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                n_result.frame_end     = 1'b1;
                n_result.checksum_good = (i_rx_byte == r_running_sum);
                n_phase                = PH_HUNT1;
            end
            default: begin
                n_phase = (i_rx_byte == i_sync_first) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT1;
            r_bytes_left  <= '0;
            r_running_sum <= '0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_bytes_left  <= n_bytes_left;
            r_running_sum <= n_running_sum;
        end
    end

    assign o_result = n_result;

endmodule

### rtl/sync_length_sum_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_sum_deframer_top
// Each accepted word's result is registered before reaching the outputs.
// Throughput: one word per cycle while the skid is empty (o_ready high).
// A two-entry output stage (result register plus skid) keeps input ready
// while one result waits. Reset is synchronous, active low: hunt restarts,
// counters clear, both sync codes read zero, outputs empty.
// ----------------------------------------------------------------------------
module sync_length_sum_deframer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [slsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  slsd_pkg::t_byte                i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  slsd_pkg::t_byte                i_rx_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output slsd_pkg::t_byte                o_data_byte,
    output logic                           o_is_frame_data,
    output logic                           o_frame_end,
    output logic                           o_checksum_good
);
    import slsd_pkg::*;

    t_byte   r_sync_first, r_sync_second;
    t_result n_result, r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    in_acc, out_take;

    assign o_ready  = !r_skid_valid;
    assign in_acc   = i_valid && o_ready;
    assign out_take = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= '0;
            r_sync_second <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_wdata;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    slsd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_acc),
        .i_rx_byte     (i_rx_byte),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .o_result      (n_result)
    );

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out       <= n_result;
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            r_skid       <= n_result;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_data_byte     = r_out.data_byte;
    assign o_is_frame_data = r_out.is_frame_data;
    assign o_frame_end     = r_out.frame_end;
    assign o_checksum_good = r_out.checksum_good;

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a word while output register is empty");

    a_good_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_checksum_good) |-> o_frame_end)
        else $error("checksum_good without frame_end");

    a_data_end_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_frame_data && o_frame_end) |-> (o_data_byte == '0))
        else $error("frame data closed a frame with nonzero length");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready && in_acc) |=> r_skid_valid)
        else $error("word accepted under stall was not held in skid");
`endif

endmodule
